@@ sv/rbps_pkg.sv @@
package rbps_pkg;

    localparam int LEVELS        = 256;
    localparam int POINTS        = 128;
    localparam int COMPARE_WIDTH = 16;

    localparam int TABLE_DEPTH = 128;
    localparam int TAB_AW      = 7;
    localparam int LVL_W       = $clog2(LEVELS);
    localparam int WAVE_W      = $clog2(POINTS);
    localparam int FRAME_W     = 9;
    localparam int CFG_W       = 24;

    localparam logic [15:0] CMP_MASK =
        (COMPARE_WIDTH >= 16) ? 16'hFFFF : 16'((32'd1 << COMPARE_WIDTH) - 32'd1);

    localparam logic [23:0] RED_MASK   = 24'hFF0000;
    localparam logic [23:0] GREEN_MASK = 24'h00FF00;
    localparam logic [23:0] BLUE_MASK  = 24'h0000FF;

    localparam logic [23:0] COLOR_RESET  = 24'hFFFFFF;
    localparam logic [7:0]  PERIOD_RESET = 8'd10;

    typedef enum logic [0:0] {
        REG_COLOR         = 1'b0,
        REG_PERIOD_REPEAT = 1'b1
    } cfg_reg_t;

    typedef enum logic [0:0] {
        ACT_TICK  = 1'b0,
        ACT_WRITE = 1'b1
    } action_t;

    typedef struct packed {
        logic        action;
        logic [6:0]  table_index;
        logic [15:0] table_value;
    } item_t;

    typedef struct packed {
        logic [15:0] red_compare;
        logic [15:0] green_compare;
        logic [15:0] blue_compare;
        logic [6:0]  wave_position;
    } result_t;

    // Low table-address bits of the wave index, zero-extended when the index is narrower.
    function automatic logic [TAB_AW-1:0] table_addr(input logic [WAVE_W-1:0] idx);
        logic [WAVE_W+TAB_AW-1:0] ext;
        ext = {{TAB_AW{1'b0}}, idx};
        return ext[TAB_AW-1:0];
    endfunction

endpackage

@@ sv/rbps_if.sv @@
interface rbps_item_if
    import rbps_pkg::*;
();
    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rbps_result_if
    import rbps_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ sv/rgb_breathing_pwm_sequencer.sv @@
// RGB breathing PWM sequencer.
// The item channel carries either a timer tick or a write of one wave table
// word. Each tick advances the level counter; ticks that bring it to levels
// 1 to LEVELS-1 produce one result transaction with three PWM compare
// values and the wave position in use. The tick that wraps the level counter
// produces nothing and advances the frame counter, which steps the wave
// position after period_repeat+1 frames. Table writes produce nothing.
// The read stage registers a tick's table read as the tick is accepted; the
// output register loads from it when empty or when its result is taken.
// Throughput: one item per cycle unless the item channel stalls; the table
// read is the single memory access each tick needs, and writes use the same
// port on their own cycle. The cfg port writes color and period_repeat; the
// user must use it only while idle; the block itself does not enforce this.
// Reset clears the counters and the pipeline and loads color 0xFFFFFF and
// period_repeat 10. The wave table is not cleared and must be written before
// it is read.
// When the receiver stalls, the result holds in the output register while one
// more result waits in the read stage; after that the item channel stalls.
module rgb_breathing_pwm_sequencer
    import rbps_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    rbps_item_if.sink            item,
    rbps_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [0:0]           cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic [15:0] wave_mem [TABLE_DEPTH];

    logic [23:0]        color_reg;
    logic [7:0]         period_reg;
    logic [LVL_W-1:0]   level_reg,  level_next;
    logic [FRAME_W-1:0] frame_reg,  frame_next;
    logic [WAVE_W-1:0]  wave_reg,   wave_next;

    logic               s1_valid_reg;
    logic [LVL_W-1:0]   s1_level_reg;
    logic [WAVE_W-1:0]  s1_wave_reg;
    logic [15:0]        rd_data_reg;

    logic               out_valid_reg;
    result_t            out_data_reg;

    logic               s1_move;
    logic               accept;
    logic               tick;
    logic               emit;
    logic [LVL_W:0]     level_inc;
    logic [FRAME_W-1:0] frame_inc;
    logic [WAVE_W:0]    wave_inc;
    logic [15:0]        word;
    logic [8:0]         lvl_ext;

    assign s1_move    = !out_valid_reg || result.ready;
    assign item.ready = !s1_valid_reg || s1_move;
    assign accept     = item.valid && item.ready;
    assign tick       = accept && (item.data.action == ACT_TICK);

    always_comb
    begin
        level_inc  = {1'b0, level_reg} + {{LVL_W{1'b0}}, 1'b1};
        frame_inc  = frame_reg + {{(FRAME_W-1){1'b0}}, 1'b1};
        wave_inc   = {1'b0, wave_reg} + {{WAVE_W{1'b0}}, 1'b1};
        level_next = level_reg;
        frame_next = frame_reg;
        wave_next  = wave_reg;
        emit       = 1'b0;
        if (tick)
        begin
            if (level_inc >= (LVL_W+1)'(LEVELS))
            begin
                level_next = '0;
                if (frame_inc > {1'b0, period_reg})
                begin
                    frame_next = '0;
                    wave_next  = (wave_inc >= (WAVE_W+1)'(POINTS)) ? '0 : wave_inc[WAVE_W-1:0];
                end
                else
                begin
                    frame_next = frame_inc;
                end
            end
            else
            begin
                level_next = level_inc[LVL_W-1:0];
                emit       = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg  <= COLOR_RESET;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_COLOR:         color_reg  <= cfg_data[23:0];
                REG_PERIOD_REPEAT: period_reg <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg     <= '0;
            frame_reg     <= '0;
            wave_reg      <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            frame_reg <= frame_next;
            wave_reg  <= wave_next;
            if (item.ready)
                s1_valid_reg <= emit;
            if (s1_move)
                out_valid_reg <= s1_valid_reg;
        end
    end

    // The table is written and read through one port; a write and a tick never
    // share a cycle, and a read sees every write accepted before it.
    always_ff @(posedge clk)
    begin
        if (accept && item.data.action == ACT_WRITE)
            wave_mem[item.data.table_index] <= item.data.table_value;
        if (tick)
            rd_data_reg <= wave_mem[table_addr(wave_reg)];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_level_reg <= level_next;
            s1_wave_reg  <= wave_reg;
        end
    end

    always_comb
    begin
        word    = rd_data_reg & CMP_MASK;
        lvl_ext = 9'(s1_level_reg);
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_valid_reg)
        begin
            out_data_reg.red_compare <=
                ({1'b0, 8'((color_reg & RED_MASK) >> 16)} >= lvl_ext) ? word : 16'd0;
            out_data_reg.green_compare <=
                ({1'b0, 8'((color_reg & GREEN_MASK) >> 8)} >= lvl_ext) ? word : 16'd0;
            out_data_reg.blue_compare <=
                ({1'b0, 8'(color_reg & BLUE_MASK)} >= lvl_ext) ? word : 16'd0;
            out_data_reg.wave_position <= table_addr(s1_wave_reg);
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

endmodule

@@ sv/rbps_checker.sv @@
module rbps_checker
    import rbps_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    item_valid,
    input logic    item_ready,
    input logic    result_valid,
    input logic    result_ready,
    input result_t result_data
);

    // A stalled result transaction keeps its valid and its payload.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result_data))
        else $error("result changed while stalled");

    // With the output register empty the block always takes an item.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> item_ready)
        else $error("item stalled with empty output");

    // All channels carry the same table word unless a channel is off.
    a_same_word_rg: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.red_compare != 16'd0
            && result_data.green_compare != 16'd0
        |-> result_data.red_compare == result_data.green_compare)
        else $error("red and green words differ");

    a_same_word_gb: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_data.green_compare != 16'd0
            && result_data.blue_compare != 16'd0
        |-> result_data.green_compare == result_data.blue_compare)
        else $error("green and blue words differ");

    // A result that appears on an empty output was accepted as a tick and passed
    // through the read stage and the output register.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid ##1 result_valid |-> $past(item_valid && item_ready, 2))
        else $error("result without a tick");

endmodule

bind rgb_breathing_pwm_sequencer rbps_checker u_rbps_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item.valid),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_data  (result.data)
);
